/* hdl/gpp_pkg.sv */
`default_nettype none

package gpp_pkg;

    // Frame buffer is kept as 16-bit pairs: {even byte, odd byte}
    localparam int PairWords  = 512;
    localparam int PairAddrW  = $clog2(PairWords);
    localparam int QueueDepth = 2;

    localparam logic [7:0] CmdExtended  = 8'h36;
    localparam logic [7:0] CmdBasic     = 8'h30;
    localparam logic [7:0] AddrBase     = 8'h80;

    // Decoded pixel request; pair_addr = {half, row[4:0], pair[2:0]}
    typedef struct packed {
        logic [PairAddrW-1:0] pair_addr;
        logic                 odd_sel;
        logic [7:0]           bit_mask;
        logic                 set_pixel;
        logic                 command;
    } item_t;

endpackage

`default_nettype wire

/* hdl/gpp_front.sv */
`default_nettype none

module gpp_front #(
    parameter int QUEUE_DEPTH = gpp_pkg::QueueDepth
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [6:0]    pixel_x,
    input  wire logic [5:0]    pixel_y,
    input  wire logic          set_pixel,
    input  wire logic          command,
    input  wire logic          clearing,
    output gpp_pkg::item_t     item,
    output logic               item_valid,
    input  wire logic          item_take
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    gpp_pkg::item_t q_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    gpp_pkg::item_t dec;
    logic push_ok;
    logic take_ok;

    // Classify: half, row, pair and byte select straight from the coordinates
    always_comb
    begin
        dec.pair_addr = {pixel_y[5], pixel_y[4:0], pixel_x[6:4]};
        dec.odd_sel   = pixel_x[3];
        dec.bit_mask  = 8'h80 >> pixel_x[2:0];
        dec.set_pixel = set_pixel;
        dec.command   = command;
    end

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH)) || clearing;
    assign push_ok    = push && !full;
    assign item_valid = (count_reg != '0);
    assign take_ok    = item_take && item_valid;
    assign item       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (take_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push_ok) - CNT_W'(take_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_mem_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

/* hdl/gpp_back.sv */
`default_nettype none

module gpp_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire gpp_pkg::item_t item,
    input  wire logic          item_valid,
    output logic               item_take,
    output logic               clearing,
    output logic               empty,
    input  wire logic          pop,
    output logic               is_data,
    output logic [7:0]         bus_byte,
    output logic               last
);

    localparam int AW = gpp_pkg::PairAddrW;

    localparam logic [1:0] StClear  = 2'd0;
    localparam logic [1:0] StIdle   = 2'd1;
    localparam logic [1:0] StModify = 2'd2;
    localparam logic [1:0] StEmit   = 2'd3;

    logic [15:0] mem [gpp_pkg::PairWords];
    logic [15:0] rd_data_reg;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [2:0]    step_reg, step_next;
    gpp_pkg::item_t cur_reg, cur_next;
    logic [15:0]   pair_reg, pair_next;

    logic          out_valid_reg, out_valid_next;
    logic          out_is_data_reg, out_is_data_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_last_reg, out_last_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [15:0]   mask16;
    logic [15:0]   new_pair;
    logic          load;
    logic          st_is_data;
    logic [7:0]    st_byte;
    logic          st_last;

    assign clearing  = (state_reg == StClear);
    assign item_take = (state_reg == StIdle) && item_valid;
    assign empty     = !out_valid_reg;
    assign is_data   = out_is_data_reg;
    assign bus_byte  = out_byte_reg;
    assign last      = out_last_reg;

    // Read-modify-write of the addressed pair
    assign mask16   = cur_reg.odd_sel ? {8'h00, cur_reg.bit_mask} : {cur_reg.bit_mask, 8'h00};
    assign new_pair = cur_reg.set_pixel ? (rd_data_reg | mask16) : (rd_data_reg & ~mask16);

    assign load = (state_reg == StEmit) && (!out_valid_reg || pop);

    // Transfer for the current step of the display update
    always_comb
    begin
        st_is_data = 1'b0;
        st_last    = 1'b0;
        case (step_reg)
            3'd0: st_byte = gpp_pkg::CmdExtended;
            3'd1: st_byte = gpp_pkg::AddrBase + {3'b000, cur_reg.pair_addr[AW-2:3]};
            3'd2: st_byte = gpp_pkg::AddrBase + {4'b0000, cur_reg.pair_addr[AW-1],
                                                 cur_reg.pair_addr[2:0]};
            3'd3:
            begin
                st_byte    = pair_reg[15:8];
                st_is_data = 1'b1;
            end
            3'd4:
            begin
                st_byte    = pair_reg[7:0];
                st_is_data = 1'b1;
            end
            default:
            begin
                st_byte = gpp_pkg::CmdBasic;
                st_last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        step_next        = step_reg;
        cur_next         = cur_reg;
        pair_next        = pair_reg;
        mem_we           = 1'b0;
        mem_waddr        = cur_reg.pair_addr;
        mem_wdata        = new_pair;
        out_valid_next   = out_valid_reg;
        out_is_data_next = out_is_data_reg;
        out_byte_next    = out_byte_reg;
        out_last_next    = out_last_reg;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            StClear:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(gpp_pkg::PairWords - 1))
                begin
                    state_next = StIdle;
                end
            end
            StIdle:
            begin
                if (item_valid)
                begin
                    cur_next   = item;
                    state_next = StModify;
                end
            end
            StModify:
            begin
                mem_we    = 1'b1;
                pair_next = new_pair;
                step_next = '0;
                state_next = cur_reg.command ? StEmit : StIdle;
            end
            StEmit:
            begin
                if (load)
                begin
                    out_valid_next   = 1'b1;
                    out_is_data_next = st_is_data;
                    out_byte_next    = st_byte;
                    out_last_next    = st_last;
                    step_next        = step_reg + 1'b1;
                    if (st_last)
                    begin
                        state_next = StIdle;
                    end
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= StClear;
            clr_addr_reg  <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg         <= cur_next;
        pair_reg        <= pair_next;
        out_is_data_reg <= out_is_data_next;
        out_byte_reg    <= out_byte_next;
        out_last_reg    <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[item.pair_addr];
    end

endmodule

`default_nettype wire

/* hdl/gdram_pixel_plot_shadow.sv */
// Order: a request is taken from the queue while its pair is read, then modified, then emitted.
//   The back end takes the next request only once it is done with the previous one; an update
//   request adds the six transfers, each held back while the output byte waits to be popped.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the frame buffer, one 16-bit
//   pair per cycle, while full stays high.
`default_nettype none

module gdram_pixel_plot_shadow #(
    parameter int QUEUE_DEPTH = gpp_pkg::QueueDepth
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [6:0] pixel_x,
    input  wire logic [5:0] pixel_y,
    input  wire logic       set_pixel,
    input  wire logic       command,
    output logic            empty,
    input  wire logic       pop,
    output logic            is_data,
    output logic [7:0]      bus_byte,
    output logic            last
);

    gpp_pkg::item_t item;
    logic           item_valid;
    logic           item_take;
    logic           clearing;

    // Front: decode each request into a pair address and bit mask, hold it in a short queue
    gpp_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .set_pixel  (set_pixel),
        .command    (command),
        .clearing   (clearing),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take)
    );

    // Back: clear the buffer after reset, then read-modify-write the pair and
    // advance through the six display transfers for update requests
    gpp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .clearing   (clearing),
        .empty      (empty),
        .pop        (pop),
        .is_data    (is_data),
        .bus_byte   (bus_byte),
        .last       (last)
    );

endmodule

`default_nettype wire

/* bench/plot_transfer_checker.sv */
`timescale 1ns / 1ps

module plot_transfer_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire logic       full,
    input  wire logic [6:0] pixel_x,
    input  wire logic [5:0] pixel_y,
    input  wire logic       set_pixel,
    input  wire logic       command,
    input  wire logic       empty,
    input  wire logic       pop,
    input  wire logic       is_data,
    input  wire logic [7:0] bus_byte,
    input  wire logic       last,
    output int              outstanding,
    output int              errors
);

    localparam logic KindInstr = 1'b0;
    localparam logic KindData  = 1'b1;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } transfer_t;

    logic [7:0] shadow_frame [1024];
    transfer_t  expected_transfers [$];
    int         mismatches = 0;

    assign errors = mismatches;

    function automatic transfer_t make_transfer(logic kind, logic [7:0] value, logic fin);
        transfer_t t;
        t.is_data  = kind;
        t.bus_byte = value;
        t.last     = fin;
        return t;
    endfunction

    task automatic plot_and_predict(logic [6:0] x, logic [5:0] y, logic s, logic c);
        logic [9:0] byte_idx;
        logic [9:0] pair_idx;
        logic [7:0] mask;
        // {half, row, column byte} is exactly half*512 + row*16 + x/8
        byte_idx = {y, x[6:3]};
        pair_idx = {y, x[6:4], 1'b0};
        mask     = 8'h80 >> x[2:0];
        if (s)
            shadow_frame[byte_idx] = shadow_frame[byte_idx] | mask;
        else
            shadow_frame[byte_idx] = shadow_frame[byte_idx] & ~mask;
        if (c)
        begin
            expected_transfers.push_back(make_transfer(KindInstr, gpp_pkg::CmdExtended, 1'b0));
            expected_transfers.push_back(make_transfer(KindInstr,
                gpp_pkg::AddrBase + {3'b000, y[4:0]}, 1'b0));
            expected_transfers.push_back(make_transfer(KindInstr,
                gpp_pkg::AddrBase + {4'b0000, y[5], x[6:4]}, 1'b0));
            expected_transfers.push_back(make_transfer(KindData, shadow_frame[pair_idx], 1'b0));
            expected_transfers.push_back(make_transfer(KindData,
                shadow_frame[pair_idx | 10'd1], 1'b0));
            expected_transfers.push_back(make_transfer(KindInstr, gpp_pkg::CmdBasic, 1'b1));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        transfer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 1024; i++)
                shadow_frame[i] = '0;
            expected_transfers.delete();
            outstanding <= 0;
        end
        else
        begin
            // Results leave only after their request was accepted, so check before predicting
            if (pop && !empty)
            begin
                if (expected_transfers.size() == 0)
                begin
                    $display("%0t: unexpected transfer is_data=%0b byte=%02h last=%0b",
                             $time, is_data, bus_byte, last);
                    mismatches++;
                end
                else
                begin
                    want = expected_transfers.pop_front();
                    if (is_data !== want.is_data)
                    begin
                        $display("%0t: is_data mismatch: expected %0b, actual %0b",
                                 $time, want.is_data, is_data);
                        mismatches++;
                    end
                    if (bus_byte !== want.bus_byte)
                    begin
                        $display("%0t: bus_byte mismatch: expected %02h, actual %02h",
                                 $time, want.bus_byte, bus_byte);
                        mismatches++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, last);
                        mismatches++;
                    end
                end
            end
            if (push && !full)
                plot_and_predict(pixel_x, pixel_y, set_pixel, command);
            outstanding <= expected_transfers.size();
        end
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    logic       full;
    logic [6:0] pixel_x   = '0;
    logic [5:0] pixel_y   = '0;
    logic       set_pixel = 1'b0;
    logic       command   = 1'b0;
    logic       empty;
    logic       pop       = 1'b0;
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;

    // High while both sides run without idling
    logic calm = 1'b0;

    int outstanding;
    int errors;

    always #1 clk = ~clk;

    gdram_pixel_plot_shadow i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .set_pixel (set_pixel),
        .command   (command),
        .empty     (empty),
        .pop       (pop),
        .is_data   (is_data),
        .bus_byte  (bus_byte),
        .last      (last)
    );

    plot_transfer_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .set_pixel   (set_pixel),
        .command     (command),
        .empty       (empty),
        .pop         (pop),
        .is_data     (is_data),
        .bus_byte    (bus_byte),
        .last        (last),
        .outstanding (outstanding),
        .errors      (errors)
    );

    // Receiver: stall about one cycle in five, never during the calm stretch
    always @(posedge clk)
        pop <= calm || ($urandom_range(0, 99) >= 19);

    // Offer one request and hold it until the block takes it. Occasionally
    // drop push for a random pause first so gaps land on every phase of the
    // transfer sequence.
    task automatic plot_pixel(logic [6:0] x, logic [5:0] y, logic s, logic c);
        if (!calm && $urandom_range(0, 99) < 19)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        push      <= 1'b1;
        pixel_x   <= x;
        pixel_y   <= y;
        set_pixel <= s;
        command   <= c;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Hold off the sender until every predicted transfer has been popped
    task automatic drain;
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int hot_y;
        int hot_x;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The first request clears a pixel of the freshly
        // cleared buffer, so it also checks the clearing pass after reset.
        plot_pixel(7'd0,   6'd0,  1'b0, 1'b1);
        plot_pixel(7'd0,   6'd0,  1'b1, 1'b1);   // leftmost bit, even byte
        plot_pixel(7'd15,  6'd0,  1'b1, 1'b1);   // rightmost bit, odd byte
        plot_pixel(7'd127, 6'd63, 1'b1, 1'b1);   // far corner, lower half
        plot_pixel(7'd120, 6'd63, 1'b1, 1'b1);
        plot_pixel(7'd127, 6'd63, 1'b0, 1'b1);   // clear a set pixel
        plot_pixel(7'd64,  6'd31, 1'b1, 1'b0);   // buffer-only, no transfers
        plot_pixel(7'd65,  6'd31, 1'b1, 1'b1);   // must show the buffer-only write
        plot_pixel(7'd0,   6'd32, 1'b1, 1'b1);   // first row of the lower half
        plot_pixel(7'd127, 6'd0,  1'b1, 1'b1);
        plot_pixel(7'd0,   6'd63, 1'b1, 1'b1);
        plot_pixel(7'd7,   6'd1,  1'b1, 1'b1);
        plot_pixel(7'd8,   6'd1,  1'b1, 1'b1);
        plot_pixel(7'd8,   6'd1,  1'b0, 1'b0);   // buffer-only clear
        plot_pixel(7'd9,   6'd1,  1'b1, 1'b1);
        plot_pixel(7'd0,   6'd0,  1'b0, 1'b0);
        plot_pixel(7'd15,  6'd0,  1'b0, 1'b1);
        plot_pixel(7'd93,  6'd45, 1'b1, 1'b1);
        plot_pixel(7'd93,  6'd45, 1'b1, 1'b1);   // set an already set pixel
        plot_pixel(7'd127, 6'd63, 1'b1, 1'b0);
        plot_pixel(7'd126, 6'd63, 1'b1, 1'b1);
        drain();

        // Random part: half the requests hit one 16-pixel pair so that the
        // data bytes fill up, the rest land anywhere on the screen.
        for (int n = 0; n < 370; n++)
        begin
            if (n == 150)
                calm <= 1'b1;
            if (n == 230)
                calm <= 1'b0;
            if (n % 40 == 0)
            begin
                hot_y = $urandom_range(0, 63);
                hot_x = $urandom_range(0, 7) * 16;
            end
            if ($urandom_range(0, 1) == 1)
                plot_pixel(7'(hot_x + $urandom_range(0, 15)), 6'(hot_y),
                           $urandom_range(0, 9) < 6, $urandom_range(0, 9) < 7);
            else
                plot_pixel(7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)),
                           $urandom_range(0, 9) < 6, $urandom_range(0, 9) < 7);
        end
        drain();
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run including the clearing pass
    initial
    begin
        #200000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
